/* rtl/mpbe_pkg.sv */
package mpbe_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR0,
        ST_WR1,
        ST_READ,
        ST_HOLD
    } state_t;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] KIND_BLIT  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_COL     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_ROW     = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH     = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_EXPECTED_BYTES = 3'd4;
    localparam logic [2:0] REG_MSB_TOP        = 3'd5;

    // One result item.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       status;
        logic       blit_last;
    } res_t;

    // Mirror a byte so that bit 7 lands on bit 0.
    function automatic logic [7:0] bit_reverse8(input logic [7:0] value);
        logic [7:0] result;
        for (int i = 0; i < 8; i++) begin
            result[i] = value[7 - i];
        end
        return result;
    endfunction

endpackage

/* rtl/monochrome_page_blit_engine_top.sv */
// Monochrome page-mode framebuffer with a rectangle blit engine.
// Input requests arrive on s_tvalid/s_tready with the kind on s_tuser: a blit
// byte paints eight vertical pixels of the configured rectangle, a read returns
// one stored byte, a clear zeroes the whole store. Every request gives exactly
// one result on m_tvalid/m_tready: read data on m_tdata, the reject flag on
// m_tuser and the rectangle-complete flag on m_tlast. Registers are written on
// the cfg channel, which is always ready.
// A blit byte is one read-modify-write of each page byte that its eight rows
// touch, two when they straddle two pages, through the single write port of
// the frame memory. A clear sweeps the memory one entry per cycle, all
// (1 << (clog2(COLUMNS) + clog2(PAGES))) entries, 1024 by default.
// Results are written into an output register as the work ends; while the
// receiver stalls, the next request is still taken and runs until its own
// result is ready, then waits for the register to free up.
// Reset starts the same clearing sweep; s_tready stays low until it ends.
module monochrome_page_blit_engine_top
    import mpbe_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // src_byte[7:0], read_col[14:8], read_page[17:15], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_byte[7:0]
    output logic        m_tuser,   // status[0]
    output logic        m_tlast,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 1 << AW;
    localparam logic [8:0] COL_LIMIT  = 9'(COLUMNS);
    localparam logic [7:0] ROW_LIMIT  = 8'(8 * PAGES);
    localparam logic [4:0] PAGE_LIMIT = 5'(PAGES);
    localparam logic [AW-1:0] LAST_ADDR = {AW{1'b1}};
    localparam logic [AW-1:0] ADDR_ONE  = {{(AW-1){1'b0}}, 1'b1};

    // Frame memory.
    logic [7:0]    frame_mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_data_reg;

    // Control and architectural state.
    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_resp_reg, clr_resp_next;
    logic [7:0]    col_offset_reg, col_offset_next;
    logic [3:0]    band_index_reg, band_index_next;
    logic [6:0]    origin_col_reg, origin_col_next;
    logic [5:0]    origin_row_reg, origin_row_next;
    logic [7:0]    rect_width_reg, rect_width_next;
    logic [6:0]    rect_height_reg, rect_height_next;
    logic [10:0]   expected_bytes_reg, expected_bytes_next;
    logic          msb_top_reg, msb_top_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    res_t          out_reg, out_next;
    res_t          res_reg, res_next;
    logic [7:0]    w0_reg, w0_next, w1_reg, w1_next;
    logic [7:0]    m0_reg, m0_next, m1_reg, m1_next;
    logic [AW-1:0] addr1_reg, addr1_next;
    logic [AW-1:0] addr0_reg, addr0_next;
    logic          straddle_reg, straddle_next;
    logic          last_reg, last_next;
    logic          rd_ok_reg, rd_ok_next;

    // Input field decode.
    logic [1:0] in_kind;
    logic [7:0] in_src;
    logic [6:0] in_rcol;
    logic [2:0] in_rpage;
    assign in_kind  = s_tuser;
    assign in_src   = s_tdata[7:0];
    assign in_rcol  = s_tdata[14:8];
    assign in_rpage = s_tdata[17:15];

    // Handshakes.
    logic in_req, out_free, cfg_req;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_req    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cfg_req   = cfg_valid;

    // Geometry check on the configured rectangle.
    logic [3:0]  bands;
    logic [8:0]  col_end;
    logic [7:0]  row_end;
    logic [11:0] byte_count;
    logic        geom_ok;
    assign bands      = rect_height_reg[6:3];
    assign col_end    = {2'b0, origin_col_reg} + {1'b0, rect_width_reg};
    assign row_end    = {2'b0, origin_row_reg} + {1'b0, rect_height_reg};
    assign byte_count = {4'b0, rect_width_reg} * {8'b0, bands};
    assign geom_ok    = (rect_width_reg != 8'd0) && (rect_height_reg != 7'd0)
                     && (col_end <= COL_LIMIT) && (row_end <= ROW_LIMIT)
                     && (rect_height_reg[2:0] == 3'd0)
                     && (byte_count == {1'b0, expected_bytes_reg});

    // Placement of the current byte; counters outside the rectangle restart.
    logic        stale;
    logic [7:0]  co_eff;
    logic [3:0]  band_eff;
    logic [8:0]  col_sum;
    logic [7:0]  row_sum;
    logic [4:0]  page0, page1;
    logic [7:0]  pix;
    logic [15:0] w16, m16;
    logic [8:0]  co_inc;
    logic [4:0]  band_inc;
    logic        wrap_col, wrap_band;
    assign stale     = (col_offset_reg >= rect_width_reg) || (band_index_reg >= bands);
    assign co_eff    = stale ? 8'd0 : col_offset_reg;
    assign band_eff  = stale ? 4'd0 : band_index_reg;
    assign col_sum   = {2'b0, origin_col_reg} + {1'b0, co_eff};
    assign row_sum   = {2'b0, origin_row_reg} + {1'b0, band_eff, 3'b0};
    assign page0     = row_sum[7:3];
    assign page1     = page0 + 5'd1;
    assign pix       = msb_top_reg ? bit_reverse8(in_src) : in_src;
    assign w16       = {8'b0, pix} << row_sum[2:0];
    assign m16       = 16'h00FF << row_sum[2:0];
    assign co_inc    = {1'b0, co_eff} + 9'd1;
    assign band_inc  = {1'b0, band_eff} + 5'd1;
    assign wrap_col  = (co_inc >= {1'b0, rect_width_reg});
    assign wrap_band = (band_inc >= {1'b0, bands});

    // Read address range check.
    logic [8:0] rcol_ext;
    logic [4:0] rpage_ext;
    logic       rd_in_range;
    assign rcol_ext    = {2'b0, in_rcol};
    assign rpage_ext   = {2'b0, in_rpage};
    assign rd_in_range = (rcol_ext < COL_LIMIT) && (rpage_ext < PAGE_LIMIT);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    if (clr_resp_reg && !out_free) begin
                        state_next = ST_HOLD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (in_req) begin
                    case (in_kind)
                        KIND_BLIT:  state_next = geom_ok ? ST_WR0
                                               : (out_free ? ST_IDLE : ST_HOLD);
                        KIND_READ:  state_next = ST_READ;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = out_free ? ST_IDLE : ST_HOLD;
                    endcase
                end
            end
            ST_WR0: begin
                if (straddle_reg) begin
                    state_next = ST_WR1;
                end else begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_WR1, ST_READ, ST_HOLD: begin
                state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result hand-off.
    logic finish;
    res_t res;
    always_comb begin
        finish              = 1'b0;
        res                 = '0;
        mem_we              = 1'b0;
        mem_waddr           = addr0_reg;
        mem_wdata           = 8'd0;
        mem_raddr           = addr1_reg;
        clr_addr_next       = clr_addr_reg;
        clr_resp_next       = clr_resp_reg;
        col_offset_next     = col_offset_reg;
        band_index_next     = band_index_reg;
        origin_col_next     = origin_col_reg;
        origin_row_next     = origin_row_reg;
        rect_width_next     = rect_width_reg;
        rect_height_next    = rect_height_reg;
        expected_bytes_next = expected_bytes_reg;
        msb_top_next        = msb_top_reg;
        res_next            = res_reg;
        w0_next             = w0_reg;
        w1_next             = w1_reg;
        m0_next             = m0_reg;
        m1_next             = m1_reg;
        addr0_next          = addr0_reg;
        addr1_next          = addr1_reg;
        straddle_next       = straddle_reg;
        last_next           = last_reg;
        rd_ok_next          = rd_ok_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_ONE;
                if (clr_addr_reg == LAST_ADDR) begin
                    finish        = clr_resp_reg;
                    clr_resp_next = 1'b0;
                end
            end
            ST_IDLE: begin
                // Start the read of the first page byte, or of the requested byte.
                if (in_kind == KIND_READ) begin
                    mem_raddr = {rcol_ext[CW-1:0], rpage_ext[PW-1:0]};
                end else begin
                    mem_raddr = {col_sum[CW-1:0], page0[PW-1:0]};
                end
                if (in_req) begin
                    case (in_kind)
                        KIND_BLIT: begin
                            if (geom_ok) begin
                                w0_next       = w16[7:0];
                                w1_next       = w16[15:8];
                                m0_next       = m16[7:0];
                                m1_next       = m16[15:8];
                                addr0_next    = {col_sum[CW-1:0], page0[PW-1:0]};
                                addr1_next    = {col_sum[CW-1:0], page1[PW-1:0]};
                                straddle_next = (row_sum[2:0] != 3'd0);
                                last_next     = wrap_col && wrap_band;
                                if (!wrap_col) begin
                                    col_offset_next = co_inc[7:0];
                                    band_index_next = band_eff;
                                end else if (!wrap_band) begin
                                    col_offset_next = 8'd0;
                                    band_index_next = band_inc[3:0];
                                end else begin
                                    col_offset_next = 8'd0;
                                    band_index_next = 4'd0;
                                end
                            end else begin
                                finish     = 1'b1;
                                res.status = 1'b1;
                            end
                        end
                        KIND_READ: begin
                            rd_ok_next = rd_in_range;
                        end
                        KIND_CLEAR: begin
                            clr_resp_next = 1'b1;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_WR0: begin
                // Merge into the first page byte and fetch the second.
                mem_we    = 1'b1;
                mem_waddr = addr0_reg;
                mem_wdata = (rd_data_reg & ~m0_reg) | w0_reg;
                mem_raddr = addr1_reg;
                if (!straddle_reg) begin
                    finish        = 1'b1;
                    res.blit_last = last_reg;
                end
            end
            ST_WR1: begin
                mem_we        = 1'b1;
                mem_waddr     = addr1_reg;
                mem_wdata     = (rd_data_reg & ~m1_reg) | w1_reg;
                finish        = 1'b1;
                res.blit_last = last_reg;
            end
            ST_READ: begin
                finish        = 1'b1;
                res.read_byte = rd_ok_reg ? rd_data_reg : 8'd0;
            end
            ST_HOLD: begin
                finish = 1'b1;
                res    = res_reg;
            end
            default: begin
                finish = 1'b0;
            end
        endcase

        if (finish && !out_free) begin
            res_next = res;
        end

        // A write to any of the six known registers restarts the blit stream.
        if (cfg_req) begin
            case (cfg_index)
                REG_ORIGIN_COL:     origin_col_next     = cfg_data[6:0];
                REG_ORIGIN_ROW:     origin_row_next     = cfg_data[5:0];
                REG_RECT_WIDTH:     rect_width_next     = cfg_data[7:0];
                REG_RECT_HEIGHT:    rect_height_next    = cfg_data[6:0];
                REG_EXPECTED_BYTES: expected_bytes_next = cfg_data;
                REG_MSB_TOP:        msb_top_next        = cfg_data[0];
                default:            msb_top_next        = msb_top_reg;
            endcase
            if (cfg_index <= REG_MSB_TOP) begin
                col_offset_next = 8'd0;
                band_index_next = 4'd0;
            end
        end
    end

    // Output register.
    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (finish && out_free) begin
            out_next      = res;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.read_byte;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.blit_last;

    // Frame memory ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            clr_resp_reg       <= 1'b0;
            col_offset_reg     <= 8'd0;
            band_index_reg     <= 4'd0;
            origin_col_reg     <= 7'd0;
            origin_row_reg     <= 6'd0;
            rect_width_reg     <= 8'd0;
            rect_height_reg    <= 7'd0;
            expected_bytes_reg <= 11'd0;
            msb_top_reg        <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            clr_addr_reg       <= clr_addr_next;
            clr_resp_reg       <= clr_resp_next;
            col_offset_reg     <= col_offset_next;
            band_index_reg     <= band_index_next;
            origin_col_reg     <= origin_col_next;
            origin_row_reg     <= origin_row_next;
            rect_width_reg     <= rect_width_next;
            rect_height_reg    <= rect_height_next;
            expected_bytes_reg <= expected_bytes_next;
            msb_top_reg        <= msb_top_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        res_reg      <= res_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        m0_reg       <= m0_next;
        m1_reg       <= m1_next;
        addr0_reg    <= addr0_next;
        addr1_reg    <= addr1_next;
        straddle_reg <= straddle_next;
        last_reg     <= last_next;
        rd_ok_reg    <= rd_ok_next;
    end

endmodule

/* rtl/mpbe_checker.sv */
module mpbe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // Reset starts the clearing sweep: no result and no request taken.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or request ready right after reset");

    // A rejected blit never completes the rectangle.
    a_reject_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("rejected blit flagged as rectangle end");

    // Only read results carry data; blit results come back as zero.
    a_blit_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser || m_tlast) |-> m_tdata == 8'd0)
        else $error("blit result carries read data");

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

endmodule

bind monochrome_page_blit_engine_top mpbe_checker u_mpbe_checker (.*);

/* tb/sv/page_blit_checker.sv */
// Watches the request, result and register channels of the blit engine, keeps its own
// copy of the framebuffer and the blit counters, and compares every result with the
// oldest outstanding prediction.
module page_blit_checker
    import mpbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB_COLS  = 128;
    localparam int FB_PAGES = 8;

    // Shadow framebuffer, one byte per column and page.
    logic [7:0]  frame_mem [0:FB_COLS*FB_PAGES-1];

    // Shadow rectangle registers.
    logic [6:0]  org_col;
    logic [5:0]  org_row;
    logic [7:0]  wid;
    logic [6:0]  hgt;
    logic [10:0] byte_total;
    logic        msb_first;

    // Position of the next source byte inside the rectangle.
    logic [7:0]  col_pos;
    logic [3:0]  band_pos;

    res_t        awaited_results[$];
    res_t        want;
    int          n_in;
    int          n_out;

    assign pending = n_in - n_out;

    function automatic void wipe_frame();
        for (int i = 0; i < FB_COLS*FB_PAGES; i++) begin
            frame_mem[i] = 8'h00;
        end
    endfunction

    // A blit is only placed when the rectangle is non-empty, on screen, whole bands
    // tall and matched by the programmed byte count.
    function automatic bit rect_fits();
        if (wid == 8'd0 || hgt == 7'd0) return 1'b0;
        if (int'(org_col) + int'(wid) > FB_COLS) return 1'b0;
        if (int'(org_row) + int'(hgt) > 8 * FB_PAGES) return 1'b0;
        if (hgt[2:0] != 3'd0) return 1'b0;
        if (int'(wid) * int'(hgt >> 3) != int'(byte_total)) return 1'b0;
        return 1'b1;
    endfunction

    // Any write to a known register restarts the source stream.
    task automatic apply_register(input logic [2:0] idx, input logic [10:0] value);
        bit known;
        known = 1'b1;
        case (idx)
            REG_ORIGIN_COL:     org_col    = value[6:0];
            REG_ORIGIN_ROW:     org_row    = value[5:0];
            REG_RECT_WIDTH:     wid        = value[7:0];
            REG_RECT_HEIGHT:    hgt        = value[6:0];
            REG_EXPECTED_BYTES: byte_total = value;
            REG_MSB_TOP:        msb_first  = value[0];
            default:            known      = 1'b0;
        endcase
        if (known) begin
            col_pos  = 8'd0;
            band_pos = 4'd0;
        end
    endtask

    // Applies one request to the shadow state and returns the result it should give.
    function automatic res_t frame_step(input logic [1:0] kind, input logic [23:0] data);
        res_t        r;
        int          bands;
        int          col;
        int          row;
        int          pg;
        logic [7:0]  src;
        logic        px;
        r   = '0;
        src = data[7:0];
        case (kind)
            KIND_BLIT: begin
                if (!rect_fits()) begin
                    r.status = 1'b1;
                end else begin
                    bands = int'(hgt >> 3);
                    if (int'(col_pos) >= int'(wid) || int'(band_pos) >= bands) begin
                        col_pos  = 8'd0;
                        band_pos = 4'd0;
                    end
                    col = int'(org_col) + int'(col_pos);
                    row = int'(org_row) + 8 * int'(band_pos);
                    for (int i = 0; i < 8; i++) begin
                        px = msb_first ? src[7 - i] : src[i];
                        pg = (row + i) >> 3;
                        if (col < FB_COLS && pg < FB_PAGES) begin
                            frame_mem[col * FB_PAGES + pg][(row + i) & 7] = px;
                        end
                    end
                    col_pos = col_pos + 8'd1;
                    if (col_pos >= wid) begin
                        col_pos  = 8'd0;
                        band_pos = band_pos + 4'd1;
                        if (int'(band_pos) >= bands) begin
                            band_pos    = 4'd0;
                            r.blit_last = 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                r.read_byte = frame_mem[int'(data[14:8]) * FB_PAGES + int'(data[17:15])];
            end
            KIND_CLEAR: begin
                wipe_frame();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Register writes are taken before requests so that a same-edge write is seen first.
    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_frame();
            org_col    = '0;
            org_row    = '0;
            wid        = '0;
            hgt        = '0;
            byte_total = '0;
            msb_first  = 1'b0;
            col_pos    = '0;
            band_pos   = '0;
            mismatches = 0;
            awaited_results.delete();
            n_in  <= 0;
            n_out <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(frame_step(s_tuser, s_tdata));
                n_in <= n_in + 1;
            end
            if (m_tvalid && m_tready) begin
                n_out <= n_out + 1;
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: read_byte %0d status %0d last %0d",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.read_byte) begin
                        $error("read_byte: expected %0d, actual %0d", want.read_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.blit_last) begin
                        $error("blit_last: expected %0d, actual %0d", want.blit_last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Stimulus and verdict for the blit engine; all checking happens in the checker.
module tb_top
    import mpbe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The unused request kind and the two register indexes past the list.
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO  = 3'd6;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;
    localparam int         ITEM_TARGET   = 1850;
    localparam int         STEADY_FROM   = 1650;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 8000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    int          mismatches;
    int          pending;
    bit          steady_phase;
    bit          backpressure_req;
    bit          backpressure_done;
    int          requests_sent;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    monochrome_page_blit_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    page_blit_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offers one request, sometimes after a short idle burst, and waits until it is taken.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] src,
                             input logic [6:0] col, input logic [2:0] page);
        if (!steady_phase && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, page, col, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind != KIND_UNUSED) requests_sent++;
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_regs(input int oc, input int orow, input int w, input int h,
                             input int nb, input int msb);
        write_reg(REG_ORIGIN_COL,     11'(oc));
        write_reg(REG_ORIGIN_ROW,     11'(orow));
        write_reg(REG_RECT_WIDTH,     11'(w));
        write_reg(REG_RECT_HEIGHT,    11'(h));
        write_reg(REG_EXPECTED_BYTES, 11'(nb));
        write_reg(REG_MSB_TOP,        11'(msb));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Usually reads a byte that the current rectangle covers; otherwise, and always for an empty one, anywhere.
    task automatic read_near(input int oc, input int orow, input int w, input int h);
        int col;
        int row;
        if (w > 0 && h > 0 && $urandom_range(0, 4) != 0) begin
            col = oc + $urandom_range(0, w - 1);
            row = orow + $urandom_range(0, h - 1);
            send_item(KIND_READ, 8'($urandom), 7'(col), 3'(row >> 3));
        end else begin
            send_item(KIND_READ, 8'($urandom), 7'($urandom), 3'($urandom));
        end
    endtask

    // Receiver: short random stalls, one long hold-off on request, none at the end.
    initial begin
        m_tready = 1'b0;
        backpressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (backpressure_req && !backpressure_done) begin
                backpressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel has moved for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int oc;
        int orow;
        int w;
        int h;
        int nb;
        int pick;
        int slots;
        int roll;
        int phase;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = KIND_BLIT;
        cfg_valid        = 1'b0;
        cfg_index        = REG_ORIGIN_COL;
        cfg_data         = '0;
        steady_phase     = 1'b0;
        backpressure_req = 1'b0;
        requests_sent    = 0;
        oc = 0; orow = 0; w = 0; h = 0; nb = 0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers describe an empty rectangle, so the blit is rejected.
        send_item(KIND_BLIT, 8'hA5, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 3'd0);
        send_item(KIND_UNUSED, 8'hFF, 7'h7F, 3'h7);
        drain();

        // One byte in the bottom-right corner with bit 7 on top.
        load_regs(127, 56, 1, 8, 1, 1);
        send_item(KIND_BLIT, 8'h81, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd127, 3'd7);
        drain();

        // Full-screen rectangle: start a stream, then restart it with a register write.
        load_regs(0, 0, 128, 64, 1024, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        send_item(KIND_BLIT, 8'h3C, 7'd0, 3'd0);
        drain();
        write_reg(REG_MSB_TOP, 11'd1);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_item(KIND_BLIT, 8'h0F, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd1, 3'd0);
        drain();

        // Rows 3 to 18 straddle page borders; a write past the list leaves the stream alone.
        load_regs(0, 3, 2, 16, 4, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        drain();
        write_reg(REG_SPARE_HI, 11'h7FF);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_item(KIND_BLIT, 8'h55, 7'd0, 3'd0);
        send_item(KIND_BLIT, 8'hAA, 7'd0, 3'd0);
        send_item(KIND_BLIT, 8'h01, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd0, 3'd2);
        send_item(KIND_READ, 8'h00, 7'd1, 3'd1);
        drain();

        // Geometry failures: partial band, wrong byte count, right edge, bottom edge.
        load_regs(0, 0, 4, 12, 4, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        drain();
        load_regs(0, 0, 4, 8, 5, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        drain();
        load_regs(125, 0, 4, 8, 4, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        drain();
        load_regs(0, 60, 1, 8, 1, 0);
        send_item(KIND_BLIT, 8'hFF, 7'd0, 3'd0);
        send_item(KIND_CLEAR, 8'h00, 7'd0, 3'd0);
        send_item(KIND_READ, 8'h00, 7'd127, 3'd7);

        // Random phases: mostly well-formed rectangles, usually streamed in full, with reads between.
        phase = 0;
        while (requests_sent < ITEM_TARGET) begin
            drain();
            if (requests_sent >= STEADY_FROM) steady_phase = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                oc   = $urandom_range(0, 2047);
                orow = $urandom_range(0, 2047);
                w    = $urandom_range(0, 2047);
                h    = $urandom_range(0, 2047);
                nb   = $urandom_range(0, 2047);
                load_regs(oc, orow, w, h, nb, $urandom_range(0, 2047));
                w = 0;
                h = 0;
                slots = 8;
            end else begin
                if (pick == 1) begin
                    w = $urandom_range(1, 128);
                    h = 8;
                end else if (pick == 2) begin
                    w = $urandom_range(1, 4);
                    h = 8 * $urandom_range(1, 8);
                end else begin
                    w = $urandom_range(1, 12);
                    h = 8 * $urandom_range(1, 3);
                end
                oc   = $urandom_range(0, 128 - w);
                orow = $urandom_range(0, 64 - h);
                nb   = w * (h / 8);
                if (pick == 3) nb = nb + 1;
                load_regs(oc, orow, w, h, nb, $urandom_range(0, 1));
                if (pick == 4) begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              11'($urandom));
                    cfg_valid <= 1'b0;
                    @(posedge aclk);
                end
                slots = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nb) :
                        nb * $urandom_range(1, 2);
            end
            if (phase == 3) backpressure_req = 1'b1;
            for (int j = 0; j < slots; j++) begin
                roll = $urandom_range(0, 99);
                if (roll == 0)
                    send_item(KIND_CLEAR, 8'($urandom), 7'($urandom), 3'($urandom));
                else if (roll < 3)
                    send_item(KIND_UNUSED, 8'($urandom), 7'($urandom), 3'($urandom));
                else if (roll < 20)
                    read_near(oc, orow, w, h);
                else
                    send_item(KIND_BLIT, 8'($urandom), 7'($urandom), 3'($urandom));
            end
            for (int j = 0; j < 4; j++) begin
                read_near(oc, orow, w, h);
            end
            phase++;
        end

        drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mpbe_pkg.sv
rtl/monochrome_page_blit_engine_top.sv
rtl/mpbe_checker.sv
tb/sv/page_blit_checker.sv
tb/sv/tb_top.sv
